/* hw/rtl/sdl_pkg.sv */
// ----------------------------------------------------------------------------
// sdl_pkg
// Shared types and codes for the S-box DDT/LAT entry core.
// ----------------------------------------------------------------------------
package sdl_pkg;

	localparam int VALUE_W    = 10;
	localparam int FIELD_W    = 8;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic KIND_DDT = 1'b0;
	localparam logic KIND_LAT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_KIND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SBOX_BITS  = 1'b1;

	localparam logic [CFG_DATA_W-1:0] SBOX_BITS_RST = 4'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic store_we;
		logic start;
		logic run;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_sts_t;

endpackage

/* hw/rtl/sdl_ctrl.sv */
// ----------------------------------------------------------------------------
// sdl_ctrl
// Sequencer: takes beats, steps the datapath through the walk over the
// S-box and hands the result to the output register.
// ----------------------------------------------------------------------------
module sdl_ctrl import sdl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    cmd,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t dp_sts,
	output dp_cmd_t dp_cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		dp_cmd.store_we = 1'b0;
		dp_cmd.start    = 1'b0;
		dp_cmd.run      = 1'b0;
		dp_cmd.out_load = 1'b0;
		in_ready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == CMD_QUERY) begin
						dp_cmd.start = 1'b1;
						state_d      = ST_RUN;
					end else begin
						dp_cmd.store_we = 1'b1;
					end
				end
			end
			ST_RUN: begin
				dp_cmd.run = 1'b1;
				if (dp_sts.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					dp_cmd.out_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/sdl_dp.sv */
// ----------------------------------------------------------------------------
// sdl_dp
// S-box store with two read ports, walk counter, hit test and accumulator,
// and the result register.
// ----------------------------------------------------------------------------
module sdl_dp import sdl_pkg::*; #(
	parameter int MAX_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   dp_cmd,
	output dp_sts_t                   dp_sts,
	input  logic                      table_kind,
	input  logic [CFG_DATA_W-1:0]     sbox_bits,
	input  logic [FIELD_W-1:0]        entry_index,
	input  logic [FIELD_W-1:0]        entry_value,
	input  logic [FIELD_W-1:0]        row_sel,
	input  logic [FIELD_W-1:0]        col_sel,
	output logic signed [VALUE_W-1:0] table_value,
	output logic [FIELD_W-1:0]        row_echo,
	output logic [FIELD_W-1:0]        col_echo
);

	localparam int DEPTH = 1 << MAX_BITS;

	logic [MAX_BITS-1:0] mem [DEPTH];

	logic [MAX_BITS-1:0] mask_d;
	logic [MAX_BITS-1:0] mask_q;
	logic [FIELD_W-1:0]  row_q;
	logic [FIELD_W-1:0]  col_q;
	logic [MAX_BITS-1:0] x_q;
	logic [MAX_BITS:0]   hits_q;
	logic [MAX_BITS-1:0] rd_a_s1;
	logic [MAX_BITS-1:0] rd_b_s1;
	logic [MAX_BITS-1:0] x_s1;
	logic                rd_valid_s1;

	logic [MAX_BITS-1:0] row_m;
	logic [MAX_BITS-1:0] col_m;
	logic [MAX_BITS-1:0] sx;
	logic [MAX_BITS-1:0] sy;
	logic                hit;
	logic [MAX_BITS-1:0] half;
	logic [VALUE_W-1:0]  value_d;

	// width in use clamped to 1..MAX_BITS
	always_comb begin
		for (int i = 0; i < MAX_BITS; i++) begin
			mask_d[i] = (i == 0) || (int'(sbox_bits) > i);
		end
	end

	assign row_m = row_q[MAX_BITS-1:0] & mask_q;
	assign col_m = col_q[MAX_BITS-1:0] & mask_q;
	assign sx    = rd_a_s1 & mask_q;
	assign sy    = rd_b_s1 & mask_q;

	always_comb begin
		if (table_kind == KIND_DDT) begin
			hit = ((sx ^ sy) == col_m);
		end else begin
			hit = ((^(x_s1 & row_m)) == (^(sx & col_m)));
		end
	end

	assign half = {1'b0, mask_q[MAX_BITS-1:1]} + MAX_BITS'(1);

	always_comb begin
		if (table_kind == KIND_DDT) begin
			value_d = VALUE_W'(hits_q);
		end else begin
			value_d = VALUE_W'(hits_q) - VALUE_W'(half);
		end
	end

	assign dp_sts.last = (x_q == mask_q);

	always_ff @(posedge clk) begin
		if (dp_cmd.store_we) begin
			mem[entry_index[MAX_BITS-1:0]] <= entry_value[MAX_BITS-1:0];
		end
		rd_a_s1 <= mem[x_q];
		rd_b_s1 <= mem[x_q ^ row_m];
		x_s1    <= x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= dp_cmd.run;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			mask_q <= mask_d;
			row_q  <= row_sel;
			col_q  <= col_sel;
			x_q    <= '0;
			hits_q <= '0;
		end else begin
			if (dp_cmd.run) begin
				x_q <= x_q + MAX_BITS'(1);
			end
			if (rd_valid_s1 && hit) begin
				hits_q <= hits_q + (MAX_BITS+1)'(1);
			end
		end
		if (dp_cmd.out_load) begin
			table_value <= value_d;
			row_echo    <= row_q;
			col_echo    <= col_q;
		end
	end

endmodule

/* hw/rtl/sbox_ddt_lat_entry_core.sv */
// ----------------------------------------------------------------------------
// sbox_ddt_lat_entry_core
// S-box difference distribution / linear approximation table entry unit.
// ----------------------------------------------------------------------------
// A write beat (cmd 0) stores one S-box entry and returns nothing. A query
// beat (cmd 1) walks x = 0 .. N-1 through the store, one x per cycle on two
// read ports (S[x] and S[x xor row]); the registered reads are accumulated
// through the drain state, and ST_DONE then loads the result register.
// The next beat is taken in the cycle after the load; an earlier result
// still waiting on out_ready holds the load back until it leaves. The
// store is not cleared by reset; every entry a query touches must have
// been written first.
// The cfg port sets table_kind and sbox_bits; the user must write them only while idle (not enforced by the block).
// ----------------------------------------------------------------------------
module sbox_ddt_lat_entry_core import sdl_pkg::*; #(
	parameter int MAX_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [FIELD_W-1:0]        entry_index,
	input  logic [FIELD_W-1:0]        entry_value,
	input  logic [FIELD_W-1:0]        row_sel,
	input  logic [FIELD_W-1:0]        col_sel,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] table_value,
	output logic [FIELD_W-1:0]        row_echo,
	output logic [FIELD_W-1:0]        col_echo,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	logic                  table_kind_q;
	logic [CFG_DATA_W-1:0] sbox_bits_q;
	dp_cmd_t               dp_cmd;
	dp_sts_t               dp_sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_kind_q <= KIND_DDT;
			sbox_bits_q  <= SBOX_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_KIND: table_kind_q <= cfg_data[0];
				REG_SBOX_BITS:  sbox_bits_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sdl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_sts    (dp_sts),
		.dp_cmd    (dp_cmd)
	);

	sdl_dp #(
		.MAX_BITS (MAX_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.dp_sts      (dp_sts),
		.table_kind  (table_kind_q),
		.sbox_bits   (sbox_bits_q),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.row_sel     (row_sel),
		.col_sel     (col_sel),
		.table_value (table_value),
		.row_echo    (row_echo),
		.col_echo    (col_echo)
	);

endmodule
